[rtl/assert_macros.svh]
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/tts_pkg.sv]
package tts_pkg;

    localparam int unsigned EXPR_MAX_DEF = 8192;
    localparam int unsigned WS_HOLD_DEF  = 32;
    localparam int unsigned QDEPTH       = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_SYN  = 2'd2;
    localparam logic [1:0] ST_LIM  = 2'd3;

    typedef enum logic [6:0] {
        M_INIT   = 7'b0000001,
        M_TEXT   = 7'b0000010,
        M_CMD    = 7'b0000100,
        M_EXPR   = 7'b0001000,
        M_DONE   = 7'b0010000,
        M_SYNERR = 7'b0100000,
        M_LIMERR = 7'b1000000
    } t_mode;

    typedef enum logic [2:0] {
        T_OPENCMD = 3'd0,
        T_OPENEXP = 3'd1,
        T_CLOSE   = 3'd2,
        T_TRIM    = 3'd3,
        T_ESCOPEN = 3'd4,
        T_ESCCLS  = 3'd5,
        T_TEXT    = 3'd6,
        T_END     = 3'd7
    } t_tok;

    typedef enum logic [2:0] {
        STR_HDR        = 3'd0,
        STR_CLOSE_TEXT = 3'd1,
        STR_CLOSE_CMD  = 3'd2,
        STR_CLOSE_EXPR = 3'd3,
        STR_OPEN_TEXT  = 3'd4,
        STR_SQ_ESC     = 3'd5,
        STR_OPEN_EXPR  = 3'd6,
        STR_DQ_ESC     = 3'd7
    } t_str;

    // one queue slot: a token, or a bare item marker when has_tok is low
    typedef struct packed {
        logic       has_tok;
        t_tok       tok;
        logic [7:0] c0;
        logic       last;
    } t_entry;

    function automatic logic [3:0] str_len(t_str s);
        logic [3:0] n;
        case (s)
            STR_HDR:        n = 4'd7;
            STR_CLOSE_TEXT: n = 4'd2;
            STR_CLOSE_CMD:  n = 4'd1;
            STR_CLOSE_EXPR: n = 4'd2;
            STR_OPEN_TEXT:  n = 4'd11;
            STR_SQ_ESC:     n = 4'd4;
            STR_OPEN_EXPR:  n = 4'd11;
            STR_DQ_ESC:     n = 4'd2;
            default:        n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] str_byte(t_str s, logic [3:0] i);
        logic [87:0] t;
        logic [6:0]  sh;
        case (s)
            STR_HDR:        t = 88'("set -e\n");
            STR_CLOSE_TEXT: t = 88'("'\n");
            STR_CLOSE_CMD:  t = 88'("\n");
            STR_CLOSE_EXPR: t = 88'("\"\n");
            STR_OPEN_TEXT:  t = 88'("printf %s '");
            STR_SQ_ESC:     t = 88'("'\\''");
            STR_OPEN_EXPR:  t = 88'("printf %s \"");
            STR_DQ_ESC:     t = 88'("\\\"");
            default:        t = '0;
        endcase
        sh = 7'({3'd0, str_len(s) - 4'd1 - i} * 7'd8);
        return t[sh +: 8];
    endfunction

    function automatic t_mode next_mode(t_tok tok, t_mode from);
        logic  opn;
        t_mode body;
        t_mode nx;
        opn = (from == M_INIT) || (from == M_TEXT);
        case (from)
            M_CMD:   body = M_CMD;
            M_EXPR:  body = M_EXPR;
            default: body = M_TEXT;
        endcase
        case (tok)
            T_OPENCMD: nx = opn ? M_CMD : M_SYNERR;
            T_OPENEXP: nx = opn ? M_EXPR : M_SYNERR;
            T_CLOSE:   nx = opn ? M_SYNERR : M_INIT;
            T_TRIM:    nx = opn ? M_SYNERR : M_INIT;
            T_END:     nx = opn ? M_DONE : M_SYNERR;
            default:   nx = body;
        endcase
        return nx;
    endfunction

endpackage

[rtl/template_to_script_translator.sv]
// The script header, 7 beats, goes out ahead of the first result beat.
// Throughput: at most one result beat per cycle; the back end finishes an item before it
// takes the next one from the queue.
// End of input drains the 2-byte lookahead at 1 token per cycle while the queue is not
// full, before finishing.
// Reset: synchronous, active low; clears mode, lookahead, queue and counters, line = 1.
module template_to_script_translator #(
    parameter int unsigned EXPR_MAX = tts_pkg::EXPR_MAX_DEF,
    parameter int unsigned WS_HOLD  = tts_pkg::WS_HOLD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] end_of_input
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_byte, [23:8] line_number
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast
);
    logic            w_push, w_full, w_pop, w_empty;
    tts_pkg::t_entry w_qin, w_qout;
    logic [7:0]      w_byte;
    logic [15:0]     w_line;

    tts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_eoi   (i_s_axis_tuser),
        .o_push  (w_push),
        .o_entry (w_qin),
        .i_full  (w_full)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_qin),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_qout),
        .o_empty (w_empty)
    );

    tts_back #(
        .EXPR_MAX (EXPR_MAX),
        .WS_HOLD  (WS_HOLD)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_entry  (w_qout),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (w_byte),
        .o_status (o_m_axis_tuser),
        .o_line   (w_line),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_line, w_byte};
endmodule

[rtl/tts_front.sv]
module tts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_eoi,
    output logic           o_push,
    output tts_pkg::t_entry o_entry,
    input  logic           i_full
);
    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_FLUSH = 2'b10
    } t_fst;

    t_fst       r_st, n_st;
    logic [7:0] r_la0, n_la0, r_la1, n_la1;
    logic [1:0] r_cnt, n_cnt;
    logic       w_lp, w_pg;

    assign w_lp = (r_la0 == tts_pkg::CH_LT) && (r_la1 == tts_pkg::CH_PCT);
    assign w_pg = (r_la0 == tts_pkg::CH_PCT) && (r_la1 == tts_pkg::CH_GT);

    always_comb begin
        n_st            = r_st;
        n_la0           = r_la0;
        n_la1           = r_la1;
        n_cnt           = r_cnt;
        o_push          = 1'b0;
        o_entry.has_tok = 1'b0;
        o_entry.tok     = tts_pkg::T_TEXT;
        o_entry.c0      = r_la0;
        o_entry.last    = 1'b0;
        o_ready         = (r_st == F_IDLE) && !i_full;
        case (r_st)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    if (i_eoi) begin
                        n_st = F_FLUSH;
                    end else if (r_cnt == 2'd0) begin
                        n_la0        = i_byte;
                        n_cnt        = 2'd1;
                        o_push       = 1'b1;
                        o_entry.last = 1'b1;
                    end else if (r_cnt == 2'd1) begin
                        n_la1        = i_byte;
                        n_cnt        = 2'd2;
                        o_push       = 1'b1;
                        o_entry.last = 1'b1;
                    end else begin
                        o_push          = 1'b1;
                        o_entry.has_tok = 1'b1;
                        o_entry.last    = 1'b1;
                        n_cnt           = 2'd0;
                        if (w_lp && i_byte == tts_pkg::CH_EQ) begin
                            o_entry.tok = tts_pkg::T_OPENEXP;
                        end else if (r_la0 == tts_pkg::CH_DASH && r_la1 == tts_pkg::CH_PCT
                                     && i_byte == tts_pkg::CH_GT) begin
                            o_entry.tok = tts_pkg::T_TRIM;
                        end else if (w_lp && i_byte == tts_pkg::CH_PCT) begin
                            o_entry.tok = tts_pkg::T_ESCOPEN;
                        end else if (r_la0 == tts_pkg::CH_PCT && r_la1 == tts_pkg::CH_PCT
                                     && i_byte == tts_pkg::CH_GT) begin
                            o_entry.tok = tts_pkg::T_ESCCLS;
                        end else if (w_lp || w_pg) begin
                            o_entry.tok = w_lp ? tts_pkg::T_OPENCMD : tts_pkg::T_CLOSE;
                            n_la0       = i_byte;
                            n_cnt       = 2'd1;
                        end else begin
                            n_la0 = r_la1;
                            n_la1 = i_byte;
                            n_cnt = 2'd2;
                        end
                    end
                end
            end
            F_FLUSH: begin
                if (!i_full) begin
                    o_push          = 1'b1;
                    o_entry.has_tok = 1'b1;
                    if (r_cnt == 2'd2) begin
                        if (w_lp || w_pg) begin
                            o_entry.tok = w_lp ? tts_pkg::T_OPENCMD : tts_pkg::T_CLOSE;
                            n_cnt       = 2'd0;
                        end else begin
                            n_la0 = r_la1;
                            n_cnt = 2'd1;
                        end
                    end else if (r_cnt == 2'd1) begin
                        n_cnt = 2'd0;
                    end else begin
                        o_entry.tok  = tts_pkg::T_END;
                        o_entry.last = 1'b1;
                        n_st         = F_IDLE;
                    end
                end
            end
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= F_IDLE;
            r_la0 <= '0;
            r_la1 <= '0;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_la0 <= n_la0;
            r_la1 <= n_la1;
            r_cnt <= n_cnt;
        end
    end
endmodule

[rtl/tts_queue.sv]
module tts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tts_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output tts_pkg::t_entry o_entry,
    output logic            o_empty
);
    localparam int unsigned D  = tts_pkg::QDEPTH;
    localparam int unsigned AW = $clog2(D);

    tts_pkg::t_entry r_mem [D];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(D - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(D - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

[rtl/tts_back.sv]
`include "assert_macros.svh"

module tts_back #(
    parameter int unsigned EXPR_MAX = tts_pkg::EXPR_MAX_DEF,
    parameter int unsigned WS_HOLD  = tts_pkg::WS_HOLD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  tts_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic [1:0]      o_status,
    output logic [15:0]     o_line,
    output logic            o_last
);
    localparam int unsigned EL_W = $clog2(EXPR_MAX) + 1;
    localparam int unsigned HC_W = $clog2(WS_HOLD + 1);
    localparam int unsigned HA_W = $clog2(WS_HOLD);

    typedef enum logic [7:0] {
        B_IDLE  = 8'b00000001,
        B_ACT   = 8'b00000010,
        B_STR   = 8'b00000100,
        B_CHK   = 8'b00001000,
        B_CHAR  = 8'b00010000,
        B_FLUSH = 8'b00100000,
        B_STAT  = 8'b01000000,
        B_END   = 8'b10000000
    } t_bst;

    t_bst              r_st, n_st, r_ret, n_ret;
    tts_pkg::t_mode    r_mode, n_mode, r_from, n_from;
    tts_pkg::t_tok     r_tok, n_tok;
    tts_pkg::t_str     r_sid, n_sid;
    logic [7:0]        r_c0, n_c0;
    logic              r_last, n_last, r_first, n_first;
    logic              r_trim, n_trim, r_skip, n_skip;
    logic              r_hdr_sent, n_hdr_sent;
    logic [2:0]        r_hidx, n_hidx;
    logic [HC_W-1:0]   r_held, n_held, r_fk, n_fk;
    logic [EL_W-1:0]   r_el, n_el;
    logic [15:0]       r_line, n_line;
    logic [1:0]        r_ci, n_ci, r_stat, n_stat;
    logic [3:0]        r_sidx, n_sidx;
    logic [7:0]        r_mem [WS_HOLD];
    logic [7:0]        r_rdata;

    logic              r_p_v, r_o_v, r_o_last;
    logic [7:0]        r_p_byte, r_o_byte;
    logic [1:0]        r_p_stat, r_o_stat;
    logic [15:0]       r_p_line, r_o_line;

    logic              w_ofree, w_slot, w_want, w_fire, w_done, w_we, w_rel;
    logic [7:0]        w_gbyte, w_cur;
    logic [1:0]        w_gstat, w_len;
    logic              w_ws, w_term;
    logic [EL_W:0]     w_sum;
    t_bst              w_fin;
    tts_pkg::t_mode    w_nx;

    assign w_ofree = !r_o_v || i_ready;
    assign w_slot  = !r_p_v || w_ofree;
    assign w_fire  = w_want && w_slot;
    // the pending result only counts once the script header is out
    assign w_done  = w_fire && r_hdr_sent;
    assign w_fin   = r_last ? B_END : B_IDLE;
    assign w_term  = (r_mode == tts_pkg::M_DONE) || (r_mode == tts_pkg::M_SYNERR)
                     || (r_mode == tts_pkg::M_LIMERR);

    always_comb begin
        case (r_tok)
            tts_pkg::T_TEXT:    w_len = {1'b0, r_c0 != 8'd0};
            tts_pkg::T_ESCOPEN: w_len = 2'd2;
            tts_pkg::T_ESCCLS:  w_len = 2'd2;
            default:            w_len = 2'd0;
        endcase
        case (r_tok)
            tts_pkg::T_ESCOPEN: w_cur = (r_ci == 2'd0) ? tts_pkg::CH_LT : tts_pkg::CH_PCT;
            tts_pkg::T_ESCCLS:  w_cur = (r_ci == 2'd0) ? tts_pkg::CH_PCT : tts_pkg::CH_GT;
            default:            w_cur = r_c0;
        endcase
    end

    assign w_ws  = (w_cur == tts_pkg::CH_SP) || (w_cur == tts_pkg::CH_TAB)
                   || (w_cur == tts_pkg::CH_NL);
    assign w_sum = (EL_W+1)'(r_el) + (EL_W+1)'(w_len);
    assign w_nx  = tts_pkg::next_mode(i_entry.tok, r_mode);

    always_comb begin
        n_st = r_st;     n_ret = r_ret;   n_mode = r_mode; n_from = r_from;
        n_tok = r_tok;   n_sid = r_sid;   n_c0 = r_c0;     n_last = r_last;
        n_first = r_first; n_trim = r_trim; n_skip = r_skip;
        n_held = r_held; n_fk = r_fk;     n_el = r_el;     n_line = r_line;
        n_ci = r_ci;     n_stat = r_stat; n_sidx = r_sidx;
        o_pop = 1'b0;    w_want = 1'b0;   w_we = 1'b0;
        w_gbyte = 8'd0;  w_gstat = tts_pkg::ST_BYTE;
        w_rel = 1'b0;
        case (r_st)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_tok   = i_entry.tok;
                    n_c0    = i_entry.c0;
                    n_last  = i_entry.last;
                    n_first = i_entry.last;
                    n_st    = i_entry.last ? B_END : B_IDLE;
                    if (w_term) begin
                        // a finished stream answers each item once with its status
                        if (r_first) begin
                            n_st = B_STAT;
                            if (r_mode == tts_pkg::M_DONE) begin
                                n_stat = tts_pkg::ST_DONE;
                            end else if (r_mode == tts_pkg::M_SYNERR) begin
                                n_stat = tts_pkg::ST_SYN;
                            end else begin
                                n_stat = tts_pkg::ST_LIM;
                            end
                        end
                    end else if (i_entry.has_tok) begin
                        if (i_entry.tok == tts_pkg::T_TEXT && i_entry.c0 == tts_pkg::CH_NL) begin
                            if (r_line != 16'hFFFF) begin
                                n_line = r_line + 16'd1;
                            end
                        end
                        if (i_entry.tok == tts_pkg::T_TEXT && i_entry.c0 == tts_pkg::CH_NL
                            && r_trim) begin
                            n_trim = 1'b0;
                        end else begin
                            n_trim = (i_entry.tok == tts_pkg::T_TRIM);
                            n_from = r_mode;
                            n_mode = w_nx;
                            n_sidx = '0;
                            n_ret  = B_ACT;
                            n_st   = B_STR;
                            if (r_mode == tts_pkg::M_TEXT && w_nx != tts_pkg::M_TEXT) begin
                                n_sid = tts_pkg::STR_CLOSE_TEXT;
                            end else if (r_mode == tts_pkg::M_CMD && w_nx != tts_pkg::M_CMD) begin
                                n_sid = tts_pkg::STR_CLOSE_CMD;
                            end else if (r_mode == tts_pkg::M_EXPR
                                         && w_nx != tts_pkg::M_EXPR) begin
                                n_sid  = tts_pkg::STR_CLOSE_EXPR;
                                n_held = '0;
                            end else begin
                                n_st = B_ACT;
                            end
                        end
                    end
                end
            end
            B_ACT: begin
                n_ci   = 2'd0;
                n_sidx = '0;
                case (r_mode)
                    tts_pkg::M_SYNERR: begin
                        n_stat = tts_pkg::ST_SYN;
                        n_st   = B_STAT;
                    end
                    tts_pkg::M_DONE: begin
                        n_stat = tts_pkg::ST_DONE;
                        n_st   = B_STAT;
                    end
                    tts_pkg::M_TEXT: begin
                        n_st = B_CHAR;
                        if (r_from != tts_pkg::M_TEXT) begin
                            n_sid = tts_pkg::STR_OPEN_TEXT;
                            n_ret = B_CHAR;
                            n_st  = B_STR;
                        end
                    end
                    tts_pkg::M_CMD: n_st = (r_from == tts_pkg::M_CMD) ? B_CHAR : w_fin;
                    tts_pkg::M_EXPR: begin
                        n_st = B_CHK;
                        if (r_from != tts_pkg::M_EXPR) begin
                            n_el   = '0;
                            n_held = '0;
                            n_skip = 1'b1;
                            n_sid  = tts_pkg::STR_OPEN_EXPR;
                            n_ret  = B_CHK;
                            n_st   = B_STR;
                        end
                    end
                    default: n_st = w_fin;
                endcase
            end
            B_STR: begin
                w_want  = 1'b1;
                w_gbyte = tts_pkg::str_byte(r_sid, r_sidx);
                if (w_done) begin
                    if (r_sidx == tts_pkg::str_len(r_sid) - 4'd1) begin
                        n_st = r_ret;
                    end else begin
                        n_sidx = r_sidx + 4'd1;
                    end
                end
            end
            B_CHK: begin
                if (r_tok == tts_pkg::T_OPENEXP) begin
                    n_st = w_fin;
                end else if (w_sum >= (EL_W+1)'(EXPR_MAX)) begin
                    n_mode = tts_pkg::M_LIMERR;
                    n_stat = tts_pkg::ST_LIM;
                    n_st   = B_STAT;
                end else begin
                    n_el = w_sum[EL_W-1:0];
                    n_st = B_CHAR;
                end
            end
            B_CHAR: begin
                if (r_ci == w_len) begin
                    n_st = w_fin;
                end else begin
                    case (r_mode)
                        tts_pkg::M_TEXT: begin
                            if (w_cur == tts_pkg::CH_SQ) begin
                                n_sid  = tts_pkg::STR_SQ_ESC;
                                n_sidx = '0;
                                n_ret  = B_CHAR;
                                n_st   = B_STR;
                                n_ci   = r_ci + 2'd1;
                            end else begin
                                w_want  = 1'b1;
                                w_gbyte = w_cur;
                                if (w_done) n_ci = r_ci + 2'd1;
                            end
                        end
                        tts_pkg::M_CMD: begin
                            w_want  = 1'b1;
                            w_gbyte = w_cur;
                            if (w_done) n_ci = r_ci + 2'd1;
                        end
                        tts_pkg::M_EXPR: begin
                            if (w_ws) begin
                                if (r_skip) begin
                                    n_ci = r_ci + 2'd1;
                                end else if (r_held >= HC_W'(WS_HOLD)) begin
                                    n_mode = tts_pkg::M_LIMERR;
                                    n_stat = tts_pkg::ST_LIM;
                                    n_st   = B_STAT;
                                end else begin
                                    w_we   = 1'b1;
                                    n_held = r_held + 1'b1;
                                    n_ci   = r_ci + 2'd1;
                                end
                            end else begin
                                n_skip = 1'b0;
                                if (r_held != '0) begin
                                    n_fk = '0;
                                    n_st = B_FLUSH;
                                end else if (w_cur == tts_pkg::CH_DQ) begin
                                    n_sid  = tts_pkg::STR_DQ_ESC;
                                    n_sidx = '0;
                                    n_ret  = B_CHAR;
                                    n_st   = B_STR;
                                    n_ci   = r_ci + 2'd1;
                                end else begin
                                    w_want  = 1'b1;
                                    w_gbyte = w_cur;
                                    if (w_done) n_ci = r_ci + 2'd1;
                                end
                            end
                        end
                        default: n_st = w_fin;
                    endcase
                end
            end
            B_FLUSH: begin
                w_want  = 1'b1;
                w_gbyte = r_rdata;
                if (w_done) begin
                    if (r_fk + 1'b1 == r_held) begin
                        n_held = '0;
                        n_st   = B_CHAR;
                    end else begin
                        n_fk = r_fk + 1'b1;
                    end
                end
            end
            B_STAT: begin
                w_want  = 1'b1;
                w_gstat = r_stat;
                if (w_done) n_st = w_fin;
            end
            B_END: begin
                // close the item: the held result, if any, goes out marked last
                if (!r_p_v) begin
                    n_st = B_IDLE;
                end else if (w_ofree) begin
                    w_rel = 1'b1;
                    n_st  = B_IDLE;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    always_comb begin
        n_hdr_sent = r_hdr_sent;
        n_hidx     = r_hidx;
        if (w_fire && !r_hdr_sent) begin
            if (r_hidx == 3'd6) begin
                n_hdr_sent = 1'b1;
            end else begin
                n_hidx = r_hidx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_held[HA_W-1:0]] <= w_cur;
        end
        r_rdata <= r_mem[n_fk[HA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= B_IDLE;
            r_mode     <= tts_pkg::M_INIT;
            r_first    <= 1'b1;
            r_trim     <= 1'b0;
            r_skip     <= 1'b0;
            r_hdr_sent <= 1'b0;
            r_hidx     <= '0;
            r_held     <= '0;
            r_el       <= '0;
            r_line     <= 16'd1;
            r_p_v      <= 1'b0;
            r_o_v      <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_mode     <= n_mode;
            r_first    <= n_first;
            r_trim     <= n_trim;
            r_skip     <= n_skip;
            r_hdr_sent <= n_hdr_sent;
            r_hidx     <= n_hidx;
            r_held     <= n_held;
            r_el       <= n_el;
            r_line     <= n_line;
            if (w_fire) begin
                r_p_v <= 1'b1;
            end else if (w_rel) begin
                r_p_v <= 1'b0;
            end
            if ((w_fire && r_p_v) || w_rel) begin
                r_o_v <= 1'b1;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_from <= n_from;
        r_tok  <= n_tok;
        r_sid  <= n_sid;
        r_c0   <= n_c0;
        r_last <= n_last;
        r_fk   <= n_fk;
        r_ci   <= n_ci;
        r_stat <= n_stat;
        r_sidx <= n_sidx;
        if (w_fire) begin
            r_p_byte <= r_hdr_sent ? w_gbyte : tts_pkg::str_byte(tts_pkg::STR_HDR, {1'b0, r_hidx});
            r_p_stat <= r_hdr_sent ? w_gstat : tts_pkg::ST_BYTE;
            r_p_line <= r_line;
        end
        if ((w_fire && r_p_v) || w_rel) begin
            r_o_byte <= r_p_byte;
            r_o_stat <= r_p_stat;
            r_o_line <= r_p_line;
            r_o_last <= w_rel;
        end
    end

    assign o_valid  = r_o_v;
    assign o_byte   = r_o_byte;
    assign o_status = r_o_stat;
    assign o_line   = r_o_line;
    assign o_last   = r_o_last;

    `ASSERT_AT(a_held_bound, i_clk, i_rst_n, r_held <= HC_W'(WS_HOLD))
    `ASSERT_AT(a_expr_bound, i_clk, i_rst_n, r_el < EL_W'(EXPR_MAX))
    `ASSERT_AT(a_flush_idx, i_clk, i_rst_n, (r_st == B_FLUSH) |-> (r_fk < r_held))
    `ASSERT_NEVER(a_char_term, i_clk, i_rst_n, (r_st == B_CHAR) && w_term)
endmodule

[sim/template_to_script_translator_checker.sv]
`timescale 1ns / 100ps

module template_to_script_translator_checker
    import tts_pkg::*;
#(
    parameter int unsigned EXPR_MAX = EXPR_MAX_DEF,
    parameter int unsigned WS_HOLD  = WS_HOLD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    typedef struct packed {
        logic [7:0]  ch;
        logic [1:0]  status;
        logic [15:0] line;
        logic        last;
    } t_script_beat;

    t_script_beat script_q[$];

    t_mode       xl_mode;
    logic [7:0]  look_buf [2];
    int          look_cnt;
    logic        trim_pend;
    logic        hdr_done;
    logic        skip_ws;
    logic [7:0]  ws_store [64];
    int          ws_cnt;
    int          expr_len;
    logic [15:0] line_cnt;
    int          step_first;

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_NL;
    endfunction

    task automatic push_raw(logic [7:0] c, logic [1:0] st = ST_BYTE);
        t_script_beat b;
        b.ch = c;
        b.status = st;
        b.line = line_cnt;
        b.last = 1'b0;
        script_q.push_back(b);
    endtask

    task automatic push_beat(logic [7:0] c, logic [1:0] st);
        if (!hdr_done) begin
            hdr_done = 1'b1;
            push_raw("s"); push_raw("e"); push_raw("t"); push_raw(" ");
            push_raw("-"); push_raw("e"); push_raw(CH_NL);
        end
        push_raw(c, st);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_beat(s[i], ST_BYTE);
    endtask

    task automatic enter_error(t_mode m);
        xl_mode = m;
        push_beat(8'h00, m == M_SYNERR ? ST_SYN : ST_LIM);
    endtask

    function automatic t_mode mode_after(t_tok tok, t_mode from);
        bit opn;
        opn = from == M_INIT || from == M_TEXT;
        case (tok)
            T_OPENCMD: return opn ? M_CMD : M_SYNERR;
            T_OPENEXP: return opn ? M_EXPR : M_SYNERR;
            T_CLOSE, T_TRIM: return opn ? M_SYNERR : M_INIT;
            T_END:     return opn ? M_DONE : M_SYNERR;
            default:   return from == M_CMD ? M_CMD : (from == M_EXPR ? M_EXPR : M_TEXT);
        endcase
    endfunction

    task automatic apply_token(t_tok tok, logic [7:0] c0);
        logic [7:0] txt [2];
        int n;
        t_mode from, nx;
        n = 0;
        if (tok == T_TEXT && c0 == CH_NL) begin
            if (line_cnt != 16'hFFFF) line_cnt++;
            if (trim_pend) begin
                trim_pend = 1'b0;
                return;
            end
        end
        if (tok == T_TEXT) begin
            txt[0] = c0;
            n = (c0 != 0);
        end else if (tok == T_ESCOPEN) begin
            txt[0] = CH_LT; txt[1] = CH_PCT; n = 2;
        end else if (tok == T_ESCCLS) begin
            txt[0] = CH_PCT; txt[1] = CH_GT; n = 2;
        end
        from = xl_mode;
        nx = mode_after(tok, from);
        trim_pend = (tok == T_TRIM);
        if (from == M_TEXT && nx != M_TEXT) push_text("'\n");
        if (from == M_CMD && nx != M_CMD) push_text("\n");
        if (from == M_EXPR && nx != M_EXPR) begin
            ws_cnt = 0;
            push_text("\"\n");
        end
        xl_mode = nx;
        case (nx)
            M_SYNERR: enter_error(M_SYNERR);
            M_DONE:   push_beat(8'h00, ST_DONE);
            M_TEXT: begin
                if (from != M_TEXT) push_text("printf %s '");
                for (int i = 0; i < n; i++)
                    if (txt[i] == CH_SQ) push_text("'\\''");
                    else push_beat(txt[i], ST_BYTE);
            end
            M_CMD: if (from == M_CMD) for (int i = 0; i < n; i++) push_beat(txt[i], ST_BYTE);
            M_EXPR: begin
                if (from != M_EXPR) begin
                    push_text("printf %s \"");
                    expr_len = 0;
                    ws_cnt = 0;
                    skip_ws = 1'b1;
                end
                if (tok == T_OPENEXP) return;
                if (expr_len + n >= EXPR_MAX) begin
                    enter_error(M_LIMERR);
                    return;
                end
                expr_len += n;
                for (int i = 0; i < n; i++) begin
                    if (is_ws(txt[i])) begin
                        if (skip_ws) continue;
                        if (ws_cnt >= WS_HOLD) begin
                            enter_error(M_LIMERR);
                            return;
                        end
                        ws_store[ws_cnt++] = txt[i];
                    end else begin
                        skip_ws = 1'b0;
                        for (int k = 0; k < ws_cnt; k++) push_beat(ws_store[k], ST_BYTE);
                        ws_cnt = 0;
                        if (txt[i] == CH_DQ) push_text("\\\"");
                        else push_beat(txt[i], ST_BYTE);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // splits one token off the window front, returns bytes used
    task automatic split_token(input logic [7:0] w [3], input int n, output int used);
        t_tok tok;
        int   len;
        tok = T_TEXT;
        len = 1;
        if (n >= 3) begin
            if (w[0] == CH_LT && w[1] == CH_PCT && w[2] == CH_EQ) begin
                tok = T_OPENEXP; len = 3;
            end else if (w[0] == CH_DASH && w[1] == CH_PCT && w[2] == CH_GT) begin
                tok = T_TRIM; len = 3;
            end else if (w[0] == CH_LT && w[1] == CH_PCT && w[2] == CH_PCT) begin
                tok = T_ESCOPEN; len = 3;
            end else if (w[0] == CH_PCT && w[1] == CH_PCT && w[2] == CH_GT) begin
                tok = T_ESCCLS; len = 3;
            end
        end
        if (len == 1 && n >= 2) begin
            if (w[0] == CH_LT && w[1] == CH_PCT) begin
                tok = T_OPENCMD; len = 2;
            end else if (w[0] == CH_PCT && w[1] == CH_GT) begin
                tok = T_CLOSE; len = 2;
            end
        end
        apply_token(tok, w[0]);
        used = len;
    endtask

    task automatic translate_beat(logic [7:0] d, logic eoi);
        logic [7:0] w [3];
        int cnt, used;
        step_first = script_q.size();
        if (xl_mode inside {M_DONE, M_SYNERR, M_LIMERR}) begin
            push_beat(8'h00, xl_mode == M_DONE ? ST_DONE :
                             (xl_mode == M_SYNERR ? ST_SYN : ST_LIM));
        end else begin
            cnt = look_cnt;
            for (int i = 0; i < cnt; i++) w[i] = look_buf[i];
            if (!eoi) begin
                w[cnt++] = d;
                if (cnt == 3) begin
                    split_token(w, cnt, used);
                    for (int i = 0; i < 3 - used; i++) w[i] = w[i + used];
                    cnt -= used;
                end
                for (int i = 0; i < cnt; i++) look_buf[i] = w[i];
                look_cnt = cnt;
            end else begin
                while (cnt > 0 && !(xl_mode inside {M_DONE, M_SYNERR, M_LIMERR})) begin
                    split_token(w, cnt, used);
                    if (used > cnt) used = cnt;
                    for (int i = 0; i < cnt - used; i++) w[i] = w[i + used];
                    cnt -= used;
                end
                look_cnt = 0;
                if (!(xl_mode inside {M_DONE, M_SYNERR, M_LIMERR})) apply_token(T_END, 8'h00);
            end
        end
        if (script_q.size() > step_first) script_q[script_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_script_beat exp_b;
        if (!i_rst_n) begin
            script_q.delete();
            xl_mode = M_INIT;
            look_cnt = 0;
            trim_pend = 1'b0;
            hdr_done = 1'b0;
            skip_ws = 1'b0;
            ws_cnt = 0;
            expr_len = 0;
            line_cnt = 16'd1;
            o_fail_count = 0;
            o_result_count = 0;
        end else begin
            // results first: an input beat cannot reach the output in the same edge
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                if (script_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result beat: byte %h status %0d line %0d last %b",
                                 i_m_tdata[7:0], i_m_tuser, i_m_tdata[23:8], i_m_tlast);
                end else begin
                    exp_b = script_q.pop_front();
                    if (exp_b.ch != i_m_tdata[7:0] || exp_b.status != i_m_tuser ||
                        exp_b.line != i_m_tdata[23:8] || exp_b.last != i_m_tlast) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch: exp byte %h st %0d line %0d last %b, ",
                                      "got %h %0d %0d %b"},
                                     exp_b.ch, exp_b.status, exp_b.line, exp_b.last,
                                     i_m_tdata[7:0], i_m_tuser, i_m_tdata[23:8], i_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) translate_beat(i_s_tdata, i_s_tuser);
        end
        o_pending = script_q.size();
    end

endmodule

[sim/template_to_script_translator_tb.sv]
`timescale 1ns / 100ps

module template_to_script_translator_tb;
    import tts_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] line_number
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    int  fail_count;
    int  pending;
    int  result_count;
    int  cycle_count = 0;
    int  items_sent;
    bit  quiet;         // no idling near the end
    bit  hold_sink;     // long receiver hold-off
    byte tpl [$];

    localparam int CYCLE_LIMIT = 400000;

    template_to_script_translator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    template_to_script_translator_checker i_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("template_to_script_translator_tb: FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(negedge i_clk);
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic [7:0] d, logic eoi);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= eoi;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // sends the queued template bytes, plus an end-of-input beat when with_end is set; reset is
    // not available, so that end finishes the run and later beats hit the finished state (status repeat).
    task automatic send_tpl(bit with_end);
        foreach (tpl[i]) send_beat(tpl[i], 1'b0);
        if (with_end) send_beat(8'($urandom_range(0, 255)), 1'b1);
        tpl.delete();
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) tpl.push_back(s[i]);
    endtask

    function automatic byte rand_piece_byte(int kind);
        case (kind)
            0: return " ";
            1: return "\t";
            2: return "\n";
            3: return "'";
            4: return "\"";
            5: return 8'h00;
            6: return 8'hFF;
            default: return byte'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic add_body(int n);
        for (int i = 0; i < n; i++) begin
            byte b;
            b = rand_piece_byte($urandom_range(0, 14));
            if (b == "%" || b == "<") b = "x";
            tpl.push_back(b);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        quiet = 1'b0;
        hold_sink = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every delimiter, quotes, zero and 0xFF, trim newline
        add_str("a'b<% ls %>\n<%= \t\"x\" \n%>-<%%%%>");
        tpl.push_back(8'h00);
        tpl.push_back(8'hFF);
        add_str("<%%><% x -%>\nz");
        send_tpl(1'b0);

        // long hold-off with the sender still pushing
        hold_sink = 1'b1;
        for (int k = 0; k < 40; k++) begin
            if ($urandom_range(0, 1) == 1) begin
                add_str("<% ");
                add_body($urandom_range(1, 4));
                add_str("%>");
            end else begin
                add_body($urandom_range(1, 4));
            end
            if (tpl.size() > 6) send_tpl(1'b0);
        end
        send_tpl(1'b0);
        add_str("<%= ");
        add_body(3);
        add_str(" %>");
        send_tpl(1'b0);
        wait_drained();

        // random well-formed stream, mostly mixes of text, commands and expressions
        while (items_sent < 300) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_body($urandom_range(1, 8));
                3, 4: begin add_str("<%"); add_body($urandom_range(0, 6)); add_str("%>"); end
                5, 6: begin
                    add_str("<%=");
                    add_body($urandom_range(0, 8));
                    add_str($urandom_range(0, 1) ? "%>" : "-%>");
                end
                7: add_str($urandom_range(0, 1) ? "<%%" : "%%>");
                8: add_str("\n");
                default: begin
                    // whitespace run in an expression, near the hold limit
                    add_str("<%= a");
                    repeat ($urandom_range(20, WS_HOLD_DEF)) tpl.push_back(" ");
                    add_str("b%>");
                end
            endcase
            if (items_sent > 260) quiet = 1'b1;
            send_tpl(1'b0);
        end
        // broken ending: a stray close in text gives a syntax error, then repeats
        add_str("q%>");
        send_tpl(1'b1);
        repeat (4) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        wait_drained();
        $display("covered %0d input beats and %0d script beats: delimiters, escapes,",
                 items_sent, result_count);
        $display("whitespace holding, trim newline, stall pressure and post-error repeats");
        if (fail_count == 0) begin
            $display("template_to_script_translator_tb: PASS");
        end else begin
            $display("template_to_script_translator_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/template_to_script_translator.sv
sim/template_to_script_translator_checker.sv
sim/template_to_script_translator_tb.sv
